@@ rtl/core/risc_instruction_field_decoder_assert.svh @@
// Assertion macros for the instruction field decoder.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef RISC_INSTRUCTION_FIELD_DECODER_ASSERT_SVH
`define RISC_INSTRUCTION_FIELD_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define RIFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rifd: implication check failed");

`define RIFD_ASSERT_LATENCY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("rifd: result strobe missing after accepted word");

`else

`define RIFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define RIFD_ASSERT_LATENCY(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/rifd_pkg.sv @@
package rifd_pkg;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_LL      = 6'h30;
  localparam logic [5:0] OP_SC      = 6'h38;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Branch word offset (index + 1 + imm) must keep the byte target inside the
  // open window (-32768, 32767), i.e. the word offset within [-8191, 8191].
  localparam int unsigned BR_SUM_W = 18;
  localparam logic signed [BR_SUM_W-1:0] BR_SUM_MIN = -18'sd8191;
  localparam logic signed [BR_SUM_W-1:0] BR_SUM_MAX = 18'sd8191;

  typedef enum logic [4:0] {
    MN_SLL   = 5'd0,
    MN_SRL   = 5'd1,
    MN_JR    = 5'd2,
    MN_ADD   = 5'd3,
    MN_ADDU  = 5'd4,
    MN_SUB   = 5'd5,
    MN_SUBU  = 5'd6,
    MN_AND   = 5'd7,
    MN_OR    = 5'd8,
    MN_NOR   = 5'd9,
    MN_SLT   = 5'd10,
    MN_SLTU  = 5'd11,
    MN_BEQ   = 5'd12,
    MN_BNE   = 5'd13,
    MN_JAL   = 5'd14,
    MN_ADDI  = 5'd15,
    MN_ADDIU = 5'd16,
    MN_SLTI  = 5'd17,
    MN_SLTIU = 5'd18,
    MN_ANDI  = 5'd19,
    MN_ORI   = 5'd20,
    MN_LUI   = 5'd21,
    MN_LW    = 5'd22,
    MN_LBU   = 5'd23,
    MN_LHU   = 5'd24,
    MN_SB    = 5'd25,
    MN_SH    = 5'd26,
    MN_SW    = 5'd27,
    MN_LL    = 5'd28,
    MN_SC    = 5'd29
  } mnemonic_t;

  typedef enum logic [2:0] {
    FORM_SHIFT   = 3'd0,  // rd, rt, shamt
    FORM_REG_S   = 3'd1,  // rs
    FORM_REG3    = 3'd2,  // rd, rs, rt
    FORM_BRANCH  = 3'd3,  // rs, rt, target
    FORM_JUMP    = 3'd4,  // target
    FORM_MEM     = 3'd5,  // rt, imm(rs)
    FORM_IMM     = 3'd6   // rt, rs, imm
  } form_t;

endpackage

@@ rtl/core/risc_instruction_field_decoder.sv @@
// Instruction field decoder for a subset of a 32-bit MIPS-style instruction set.
// Input channel: drive in_instr_word and in_instr_index with start high; the
// word is taken at any rising edge where start is high and busy is low. busy
// stays low, so a new word may be issued in every cycle.
// Result channel: out_valid strobes for exactly one cycle with the decoded
// fields (mnemonic, operand form, register numbers, shift amount, immediate,
// target flag and target byte address, error flag). The receiver cannot stall
// and must take each result in the cycle it is shown.
// Path: the accepted word enters one input register stage, then the decode logic
// drives the result register. Throughput: one word per cycle, set by the single
// decode pass.
// Reset (rst_n low, synchronous) clears both stage valid flags; words in
// flight are dropped and no strobe follows until a new word is accepted.
// Unknown opcodes or functs, and branch/jump targets outside the byte window
// (-32768, 32767), raise out_decode_error and zero the mnemonic, form, target
// flag and target fields; raw register, shift and immediate fields always pass.
`include "risc_instruction_field_decoder_assert.svh"

module risc_instruction_field_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_instr_word,
  input  logic [13:0]        in_instr_index,
  output logic               out_valid,
  output logic               out_decode_error,
  output logic [4:0]         out_mnemonic,
  output logic [2:0]         out_operand_form,
  output logic [4:0]         out_reg_s,
  output logic [4:0]         out_reg_t,
  output logic [4:0]         out_reg_d,
  output logic [4:0]         out_shift_amount,
  output logic signed [15:0] out_immediate,
  output logic               out_has_target,
  output logic signed [15:0] out_target_addr
);

  import rifd_pkg::*;

  // Input stage
  logic        in_valid_r;
  logic [31:0] word_r;
  logic [13:0] index_r;

  // Result stage
  logic               out_valid_r;
  logic               err_r;
  mnemonic_t          mn_r;
  form_t              form_r;
  logic [25:0]        raw_r;
  logic               tgt_r;
  logic signed [15:0] taddr_r;

  // Decode outputs
  logic               err_nxt;
  mnemonic_t          mn_nxt;
  form_t              form_nxt;
  logic               tgt_nxt;
  logic signed [15:0] taddr_nxt;

  logic                accept;
  logic [5:0]          opcode;
  logic [5:0]          funct;
  logic [BR_SUM_W-1:0] branch_sum;
  logic                branch_ok;
  logic                jump_ok;

  // Nothing ever holds the input off: a word can enter every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  // Capture payload on accept only; hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r  <= in_instr_word;
      index_r <= in_instr_index;
    end
  end

  assign opcode = word_r[31:26];
  assign funct  = word_r[5:0];

  // Word offset of the branch target: index + 1 + sign-extended immediate.
  assign branch_sum = {{(BR_SUM_W-14){1'b0}}, index_r} + {{(BR_SUM_W-1){1'b0}}, 1'b1}
                    + {{(BR_SUM_W-16){word_r[15]}}, word_r[15:0]};
  assign branch_ok  = ($signed(branch_sum) >= BR_SUM_MIN) &&
                      ($signed(branch_sum) <= BR_SUM_MAX);

  // jal target is the 26-bit index times 4; it stays below 32767 only when
  // the upper index bits are all zero.
  assign jump_ok = (word_r[25:13] == 13'd0);

  always_comb begin
    err_nxt   = 1'b0;
    mn_nxt    = MN_SLL;
    form_nxt  = FORM_SHIFT;
    tgt_nxt   = 1'b0;
    taddr_nxt = 16'sd0;
    if (opcode == OP_SPECIAL) begin
      unique case (funct)
        FN_SLL:  begin mn_nxt = MN_SLL;  form_nxt = FORM_SHIFT; end
        FN_SRL:  begin mn_nxt = MN_SRL;  form_nxt = FORM_SHIFT; end
        FN_JR:   begin mn_nxt = MN_JR;   form_nxt = FORM_REG_S; end
        FN_ADD:  begin mn_nxt = MN_ADD;  form_nxt = FORM_REG3;  end
        FN_ADDU: begin mn_nxt = MN_ADDU; form_nxt = FORM_REG3;  end
        FN_SUB:  begin mn_nxt = MN_SUB;  form_nxt = FORM_REG3;  end
        FN_SUBU: begin mn_nxt = MN_SUBU; form_nxt = FORM_REG3;  end
        FN_AND:  begin mn_nxt = MN_AND;  form_nxt = FORM_REG3;  end
        FN_OR:   begin mn_nxt = MN_OR;   form_nxt = FORM_REG3;  end
        FN_NOR:  begin mn_nxt = MN_NOR;  form_nxt = FORM_REG3;  end
        FN_SLT:  begin mn_nxt = MN_SLT;  form_nxt = FORM_REG3;  end
        FN_SLTU: begin mn_nxt = MN_SLTU; form_nxt = FORM_REG3;  end
        default: err_nxt = 1'b1;
      endcase
    end else begin
      unique case (opcode)
        OP_BEQ: begin
          mn_nxt    = MN_BEQ;
          form_nxt  = FORM_BRANCH;
          tgt_nxt   = 1'b1;
          taddr_nxt = {branch_sum[13:0], 2'b00};
          err_nxt   = !branch_ok;
        end
        OP_BNE: begin
          mn_nxt    = MN_BNE;
          form_nxt  = FORM_BRANCH;
          tgt_nxt   = 1'b1;
          taddr_nxt = {branch_sum[13:0], 2'b00};
          err_nxt   = !branch_ok;
        end
        OP_JAL: begin
          mn_nxt    = MN_JAL;
          form_nxt  = FORM_JUMP;
          tgt_nxt   = 1'b1;
          taddr_nxt = {word_r[13:0], 2'b00};
          err_nxt   = !jump_ok;
        end
        OP_ADDI:  begin mn_nxt = MN_ADDI;  form_nxt = FORM_IMM; end
        OP_ADDIU: begin mn_nxt = MN_ADDIU; form_nxt = FORM_IMM; end
        OP_SLTI:  begin mn_nxt = MN_SLTI;  form_nxt = FORM_IMM; end
        OP_SLTIU: begin mn_nxt = MN_SLTIU; form_nxt = FORM_IMM; end
        OP_ANDI:  begin mn_nxt = MN_ANDI;  form_nxt = FORM_IMM; end
        OP_ORI:   begin mn_nxt = MN_ORI;   form_nxt = FORM_IMM; end
        OP_LUI:   begin mn_nxt = MN_LUI;   form_nxt = FORM_IMM; end
        OP_LW:    begin mn_nxt = MN_LW;    form_nxt = FORM_MEM; end
        OP_LBU:   begin mn_nxt = MN_LBU;   form_nxt = FORM_MEM; end
        OP_LHU:   begin mn_nxt = MN_LHU;   form_nxt = FORM_MEM; end
        OP_SB:    begin mn_nxt = MN_SB;    form_nxt = FORM_MEM; end
        OP_SH:    begin mn_nxt = MN_SH;    form_nxt = FORM_MEM; end
        OP_SW:    begin mn_nxt = MN_SW;    form_nxt = FORM_MEM; end
        OP_LL:    begin mn_nxt = MN_LL;    form_nxt = FORM_MEM; end
        OP_SC:    begin mn_nxt = MN_SC;    form_nxt = FORM_MEM; end
        default:  err_nxt = 1'b1;
      endcase
    end
    // Drop the decoded meaning on any error; raw fields still pass.
    if (err_nxt) begin
      mn_nxt    = MN_SLL;
      form_nxt  = FORM_SHIFT;
      tgt_nxt   = 1'b0;
      taddr_nxt = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  // Result payload advances only with a live word in the input stage.
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      err_r   <= err_nxt;
      mn_r    <= mn_nxt;
      form_r  <= form_nxt;
      raw_r   <= word_r[25:0];
      tgt_r   <= tgt_nxt;
      taddr_r <= taddr_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_decode_error = err_r;
  assign out_mnemonic     = mn_r;
  assign out_operand_form = form_r;
  assign out_reg_s        = raw_r[25:21];
  assign out_reg_t        = raw_r[20:16];
  assign out_reg_d        = raw_r[15:11];
  assign out_shift_amount = raw_r[10:6];
  assign out_immediate    = $signed(raw_r[15:0]);
  assign out_has_target   = tgt_r;
  assign out_target_addr  = taddr_r;

  // Every accepted word produces a strobe after the input and result registers.
  `RIFD_ASSERT_LATENCY(a_latency, clk, rst_n, accept, out_valid)
  // An error result carries no decoded meaning.
  `RIFD_ASSERT_IMPLY(a_err_clear, clk, rst_n, out_valid && out_decode_error,
    (out_mnemonic == MN_SLL) && (out_operand_form == FORM_SHIFT) &&
    !out_has_target && (out_target_addr == 16'sd0))
  // A target is only reported for branch or jump forms.
  `RIFD_ASSERT_IMPLY(a_tgt_form, clk, rst_n, out_valid && out_has_target,
    (out_operand_form == FORM_BRANCH) || (out_operand_form == FORM_JUMP))

endmodule
